### design/esc_pkg.sv
// Package for the epoch seconds to calendar unit.
// Holds field widths, calendar constants and the month start helper.
// No dependencies.
package esc_pkg;

  localparam int EPOCH_W = 32;
  localparam int SEC_W   = 6;
  localparam int MIN_W   = 6;
  localparam int HOUR_W  = 5;
  localparam int WDAY_W  = 3;
  localparam int YEAR_W  = 8;
  localparam int MONTH_W = 4;
  localparam int MDAY_W  = 5;

  localparam int YEAR_DAYS  = 365;
  localparam int CYCLE_DAYS = 1461;
  localparam int EPOCH_YEAR = 1970;
  localparam int BASE_YEAR  = 2000;
  localparam int EPOCH_WDAY = 4;
  localparam int WEEK_DAYS  = 7;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Day of year (from 0) on which month idx (from 0) starts.
  function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
    logic [8:0] acc;
    acc = '0;
    for (int k = 0; k < 11; k++) begin
      if (4'(k) < idx) begin
        acc = acc + 9'(MONTH_LEN[k]);
      end
    end
    if (leap && (idx > 4'd1)) begin
      acc = acc + 9'd1;
    end
    return acc;
  endfunction

endpackage

### design/esc_if.sv
// Valid/ready channel interfaces for the epoch seconds to calendar unit.
// Depends on esc_pkg for field widths.
interface esc_in_if;
  import esc_pkg::*;

  logic               valid;
  logic               ready;
  logic [EPOCH_W-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface esc_out_if;
  import esc_pkg::*;

  logic               valid;
  logic               ready;
  logic [SEC_W-1:0]   second_of_minute;
  logic [MIN_W-1:0]   minute_of_hour;
  logic [HOUR_W-1:0]  hour_of_day;
  logic [WDAY_W-1:0]  week_day;
  logic [YEAR_W-1:0]  year_offset;
  logic [MONTH_W-1:0] month_number;
  logic [MDAY_W-1:0]  day_of_month;

  modport source (
    output valid, output second_of_minute, output minute_of_hour, output hour_of_day,
    output week_day, output year_offset, output month_number, output day_of_month,
    input ready
  );
  modport sink (
    input valid, input second_of_minute, input minute_of_hour, input hour_of_day,
    input week_day, input year_offset, input month_number, input day_of_month,
    output ready
  );
endinterface

### design/esc_cdiv.sv
// Two-stage divider by a constant: reciprocal multiply, then one correction step.
// No dependencies; MUL is floor(2**SHIFT / DIV) with every x below 2**SHIFT.
module esc_cdiv #(
  parameter int XW    = 16,
  parameter int QW    = 13,
  parameter int RW    = 3,
  parameter int DIV   = 7,
  parameter int MUL   = 9362,
  parameter int SHIFT = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [XW-1:0] x_i,
  output logic [QW-1:0] q_o,
  output logic [RW-1:0] r_o
);

  localparam int MW = $clog2(MUL + 1);
  localparam int PW = XW + MW;

  logic [PW-1:0] prod_d, prod_q;
  logic [XW-1:0] x_q;
  logic [QW-1:0] q_est;
  logic [XW-1:0] qd, r_est;
  logic          corr;
  logic [QW-1:0] q_d, q_q;
  logic [RW-1:0] r_d, r_q;

  assign prod_d = PW'(x_i) * PW'(MUL);
  assign q_est  = prod_q[SHIFT +: QW];
  assign qd     = XW'(q_est) * XW'(DIV);
  assign r_est  = x_q - qd;
  assign corr   = r_est >= XW'(DIV);
  assign q_d    = corr ? q_est + 1'b1 : q_est;
  assign r_d    = RW'(corr ? r_est - XW'(DIV) : r_est);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      x_q    <= x_i;
      q_q    <= q_d;
      r_q    <= r_d;
    end
  end

  assign q_o = q_q;
  assign r_o = r_q;

endmodule

### design/epoch_seconds_to_calendar_unit.sv
// Top level of the epoch seconds to calendar unit.
// Depends on esc_pkg, esc_in_if, esc_out_if and esc_cdiv.
//
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into seconds, minutes,
// hours, weekday (0 = Sunday), year minus 2000 modulo 256, month and day of month, using
// the every-fourth-year leap rule (right for 1970 to 2099). One transaction is accepted
// per cycle while the output is not stalled; the pipeline is made of three constant dividers
// in series (seconds to days, seconds of day to hours, seconds of hour to minutes), two
// stages each, behind the input register. The unit holds no state; a stalled output holds
// the whole pipeline.
module epoch_seconds_to_calendar_unit (
  input  logic clk_i,
  input  logic rst_ni,
  esc_in_if.sink     in_i,
  esc_out_if.source  out_o
);
  import esc_pkg::*;

  localparam int DEPTH = 7;

  logic             adv;
  logic [DEPTH-1:0] vld_d, vld_q;

  assign adv   = !vld_q[DEPTH-1] || out_o.ready;
  assign vld_d = {vld_q[DEPTH-2:0], in_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  logic [EPOCH_W-1:0] x0_q;
  logic [6:0]         lo7_a_q, lo7_b_q;
  logic [3:0]         lo4_a_q, lo4_b_q;
  logic [15:0]        day_cnt;
  logic [9:0]         day_rem;
  logic [16:0]        sec_day;
  logic [HOUR_W-1:0]  hr_q5, hr_a_q, hr_b_q;
  logic [7:0]         hr_rem;
  logic [12:0]        wd_quo;
  logic [WDAY_W-1:0]  wd_q5, wd_a_q, wd_b_q;
  logic [5:0]         cyc_q5;
  logic [10:0]        cyc_rem;
  logic [MIN_W-1:0]   min_q7;
  logic [SEC_W-1:0]   sec_q7;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x0_q    <= in_i.epoch_seconds;
      lo7_a_q <= x0_q[6:0];
      lo7_b_q <= lo7_a_q;
      lo4_a_q <= lo7_b_q[3:0];
      lo4_b_q <= lo4_a_q;
      hr_a_q  <= hr_q5;
      hr_b_q  <= hr_a_q;
      wd_a_q  <= wd_q5;
      wd_b_q  <= wd_a_q;
    end
  end

  // 86400 = 128 * 675: split off the low seven bits and divide the rest by 675.
  esc_cdiv #(
    .XW(25), .QW(16), .RW(10), .DIV(675), .MUL(6362914), .SHIFT(32)
  ) u_day_div (
    .clk_i(clk_i), .en_i(adv), .x_i(x0_q[31:7]), .q_o(day_cnt), .r_o(day_rem)
  );

  assign sec_day = {day_rem, lo7_b_q};

  // 3600 = 16 * 225.
  esc_cdiv #(
    .XW(13), .QW(HOUR_W), .RW(8), .DIV(225), .MUL(291), .SHIFT(16)
  ) u_hour_div (
    .clk_i(clk_i), .en_i(adv), .x_i(sec_day[16:4]), .q_o(hr_q5), .r_o(hr_rem)
  );

  esc_cdiv #(
    .XW(16), .QW(13), .RW(WDAY_W), .DIV(WEEK_DAYS), .MUL(9362), .SHIFT(16)
  ) u_wday_div (
    .clk_i(clk_i), .en_i(adv), .x_i(day_cnt + 16'(EPOCH_WDAY)), .q_o(wd_quo), .r_o(wd_q5)
  );

  esc_cdiv #(
    .XW(16), .QW(6), .RW(11), .DIV(CYCLE_DAYS), .MUL(44), .SHIFT(16)
  ) u_cyc_div (
    .clk_i(clk_i), .en_i(adv), .x_i(day_cnt), .q_o(cyc_q5), .r_o(cyc_rem)
  );

  esc_cdiv #(
    .XW(12), .QW(MIN_W), .RW(SEC_W), .DIV(60), .MUL(68), .SHIFT(12)
  ) u_min_div (
    .clk_i(clk_i), .en_i(adv), .x_i({hr_rem, lo4_b_q}), .q_o(min_q7), .r_o(sec_q7)
  );

  // Year within the four-year cycle; the third year is the leap year.
  localparam logic [10:0] Y1 = 11'(YEAR_DAYS);
  localparam logic [10:0] Y2 = 11'(2 * YEAR_DAYS);
  localparam logic [10:0] Y3 = 11'(3 * YEAR_DAYS + 1);
  localparam logic [YEAR_W-1:0] YEAR_OFS0 = YEAR_W'(EPOCH_YEAR - BASE_YEAR);

  logic [1:0]        yr_d, yr_q;
  logic [10:0]       base_d;
  logic [8:0]        remy_q;
  logic [YEAR_W-1:0] yoff_q, yoff_b_q;

  always_comb begin
    if (cyc_rem < Y1) begin
      yr_d   = 2'd0;
      base_d = '0;
    end else if (cyc_rem < Y2) begin
      yr_d   = 2'd1;
      base_d = Y1;
    end else if (cyc_rem < Y3) begin
      yr_d   = 2'd2;
      base_d = Y2;
    end else begin
      yr_d   = 2'd3;
      base_d = Y3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      yr_q     <= yr_d;
      remy_q   <= 9'(cyc_rem - base_d);
      yoff_q   <= YEAR_W'({cyc_q5, 2'b00}) + YEAR_W'(yr_d) + YEAR_OFS0;
      yoff_b_q <= yoff_q;
    end
  end

  logic                leap;
  logic [8:0]          mstart [12];
  logic [MONTH_W-1:0]  mon_idx;
  logic [MONTH_W-1:0]  mon_q;
  logic [MDAY_W-1:0]   mday_q;

  assign leap = yr_q == 2'd2;

  always_comb begin
    mon_idx = '0;
    for (int k = 0; k < 12; k++) begin
      mstart[k] = month_start(4'(k), leap);
    end
    for (int k = 1; k < 12; k++) begin
      mon_idx = mon_idx + MONTH_W'(remy_q >= mstart[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mon_q  <= mon_idx + 1'b1;
      mday_q <= MDAY_W'(remy_q - mstart[mon_idx]) + 1'b1;
    end
  end

  assign in_i.ready             = adv;
  assign out_o.valid            = vld_q[DEPTH-1];
  assign out_o.second_of_minute = sec_q7;
  assign out_o.minute_of_hour   = min_q7;
  assign out_o.hour_of_day      = hr_b_q;
  assign out_o.week_day         = wd_b_q;
  assign out_o.year_offset      = yoff_b_q;
  assign out_o.month_number     = mon_q;
  assign out_o.day_of_month     = mday_q;

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (sec_q7 < 6'd60) && (min_q7 < 6'd60) && (hr_b_q < 5'd24))
    else $error("time of day out of range");

  a_wday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (wd_b_q < 3'd7) && (wd_quo <= 13'd7102 || !vld_q[4]))
    else $error("weekday out of range");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (mon_q >= 4'd1) && (mon_q <= 4'd12) && (mday_q >= 5'd1))
    else $error("month or day out of range");

  a_feb_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (mon_q == 4'd2)) |-> (mday_q <= 5'd29))
    else $error("february day out of range");

endmodule
